[rtl/sppc_pkg.sv]
// ----------------------------------------------------------------------------
// sppc_pkg: shared types and constants for the space packet CRC/APID checker
// Holds field widths, the verdict codes, register indexes, the CRC-16
// byte update and the structs that pass between the checker's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sppc_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned ApidW = 11;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned LenW  = 12;
  localparam int unsigned CntW  = 32;

  // Frame geometry
  localparam int unsigned MaxFrameBytesDef = 2048;
  localparam int unsigned MinFrame         = 18;

  // CRC-16/CCITT-FALSE
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

  // APID window reset values
  localparam logic [ApidW-1:0] ApidLowReset  = 11'd1280;
  localparam logic [ApidW-1:0] ApidHighReset = 11'd1407;

  // APB data width
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_SHORT    = 2'd1,
    VERDICT_APID_BAD = 2'd2,
    VERDICT_CRC_BAD  = 2'd3
  } sppc_verdict_e;

  typedef enum logic {
    REG_APID_LOW  = 1'b0,
    REG_APID_HIGH = 1'b1
  } sppc_reg_e;

  // One input item held in the input register
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } sppc_item_t;

  // Current APID window
  typedef struct packed {
    logic [ApidW-1:0] low;
    logic [ApidW-1:0] high;
  } sppc_limits_t;

  // One result item
  typedef struct packed {
    sppc_verdict_e    verdict;
    logic [ApidW-1:0] packet_apid;
    logic [CrcW-1:0]  computed_crc;
    logic [CrcW-1:0]  trailer_crc;
    logic [LenW-1:0]  frame_length;
    logic [CntW-1:0]  accepted_count;
    logic [CntW-1:0]  mismatch_count;
    logic [CntW-1:0]  reject_count;
  } sppc_result_t;

  // Eight-bit unrolled MSB-first CRC update
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/sppc_cfg.sv]
// ----------------------------------------------------------------------------
// sppc_cfg: APB register block
// Holds the inclusive APID window limits; writes keep the low 11 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sppc_cfg
  import sppc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output sppc_limits_t             limits_o
);

  logic [ApidW-1:0] low_q, low_d;
  logic [ApidW-1:0] high_q, high_d;
  logic             wr_en;
  sppc_reg_e        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = sppc_reg_e'(paddr[2]);

  // Register write decode
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_APID_LOW:  low_d  = pwdata[ApidW-1:0];
        REG_APID_HIGH: high_d = pwdata[ApidW-1:0];
        default:       low_d  = low_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= ApidLowReset;
      high_q <= ApidHighReset;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_APID_LOW:  prdata = ApbDataW'(low_q);
      REG_APID_HIGH: prdata = ApbDataW'(high_q);
      default:       prdata = '0;
    endcase
  end

  assign limits_o.low  = low_q;
  assign limits_o.high = high_q;

endmodule

`default_nettype wire

[rtl/sppc_frame.sv]
// ----------------------------------------------------------------------------
// sppc_frame: per-datagram state and verdict logic
// Tracks position, APID, the two-byte CRC delay line and the running CRC,
// forms the verdict on the last byte and keeps the three outcome counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sppc_frame
  import sppc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         go_i,
  input  wire sppc_item_t   item_i,
  input  wire sppc_limits_t limits_i,
  output sppc_result_t      result_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PosW-1:0]  pos_q, pos_d, pos_n;
  logic [CrcW-1:0]  crc_q, crc_d, crc_n;
  logic [ApidW-1:0] apid_q, apid_d, apid_n;
  logic [CrcW-1:0]  held_q, held_d, held_n;
  logic [CntW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]  mis_q, mis_d;
  logic [CntW-1:0]  rej_q, rej_d;

  logic                 keep;
  logic                 too_short;
  logic                 apid_ok;
  logic [PosW+LenW-1:0] len_ext;
  sppc_verdict_e        verdict;

  // Byte intake: update position, APID, delay line and CRC
  always_comb begin
    keep   = pos_q < PosW'(MAX_FRAME_BYTES);
    pos_n  = pos_q;
    apid_n = apid_q;
    held_n = held_q;
    crc_n  = crc_q;
    if (keep) begin
      pos_n  = pos_q + PosW'(1);
      held_n = {held_q[ByteW-1:0], item_i.data_byte};
      if (pos_q == PosW'(0)) begin
        apid_n = {item_i.data_byte[2:0], 8'h00};
      end else if (pos_q == PosW'(1)) begin
        apid_n = {apid_q[ApidW-1:ByteW], item_i.data_byte};
      end
      if (pos_q >= PosW'(MinFrame)) begin
        crc_n = crc_feed(crc_q, held_q[CrcW-1:ByteW]);
      end
    end
  end

  // Verdict, in priority order
  always_comb begin
    too_short = pos_n < PosW'(MinFrame);
    apid_ok   = (apid_n >= limits_i.low) && (apid_n <= limits_i.high);
    priority if (too_short) begin
      verdict = VERDICT_SHORT;
    end else if (!apid_ok) begin
      verdict = VERDICT_APID_BAD;
    end else if (crc_n != held_n) begin
      verdict = VERDICT_CRC_BAD;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  // Counters after this verdict
  always_comb begin
    acc_d = acc_q;
    mis_d = mis_q;
    rej_d = rej_q;
    if (go_i && item_i.last_byte) begin
      unique case (verdict)
        VERDICT_ACCEPT:   acc_d = acc_q + CntW'(1);
        VERDICT_CRC_BAD:  mis_d = mis_q + CntW'(1);
        VERDICT_SHORT,
        VERDICT_APID_BAD: rej_d = rej_q + CntW'(1);
        default:          acc_d = acc_q;
      endcase
    end
  end

  // Frame state: advance per byte, clear after the last one
  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    apid_d = apid_q;
    held_d = held_q;
    if (go_i) begin
      if (item_i.last_byte) begin
        pos_d  = '0;
        crc_d  = CrcInit;
        apid_d = '0;
        held_d = '0;
      end else begin
        pos_d  = pos_n;
        crc_d  = crc_n;
        apid_d = apid_n;
        held_d = held_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CrcInit;
      apid_q <= '0;
      held_q <= '0;
      acc_q  <= '0;
      mis_q  <= '0;
      rej_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      apid_q <= apid_d;
      held_q <= held_d;
      acc_q  <= acc_d;
      mis_q  <= mis_d;
      rej_q  <= rej_d;
    end
  end

  // Result fields; short frames report zero APID and CRCs
  assign len_ext = {LenW'(0), pos_n};

  always_comb begin
    result_o.verdict        = verdict;
    result_o.packet_apid    = too_short ? '0 : apid_n;
    result_o.computed_crc   = too_short ? '0 : crc_n;
    result_o.trailer_crc    = too_short ? '0 : held_n;
    result_o.frame_length   = len_ext[LenW-1:0];
    result_o.accepted_count = acc_d;
    result_o.mismatch_count = mis_d;
    result_o.reject_count   = rej_d;
  end

`ifndef SYNTHESIS
  logic [CntW-1:0] cnt_sum;
  assign cnt_sum = acc_q + mis_q + rej_q;

  // Each verdict bumps exactly one counter
  a_one_count_per_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.last_byte |=> cnt_sum == $past(cnt_sum) + CntW'(1))
    else $error("counter total did not advance by one");

  // No counter moves without a verdict
  a_counts_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(go_i && item_i.last_byte) |=> $stable(cnt_sum))
    else $error("counter moved without a verdict");

  // Frame state is back at reset after the last byte
  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.last_byte |=> pos_q == '0 && crc_q == CrcInit && held_q == '0)
    else $error("frame state not cleared after last byte");

  // An accept verdict means the CRCs agree
  a_accept_crc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && result_o.verdict == VERDICT_ACCEPT |->
      result_o.computed_crc == result_o.trailer_crc)
    else $error("accept verdict with CRC mismatch");
`endif

endmodule

`default_nettype wire

[rtl/space_packet_crc_apid_checker.sv]
// A verdict reaches the master side via the input register, then the output register.
// Throughput: one byte per cycle unless stalled; the eight-bit unrolled CRC update and the
//   verdict compare sit in one stage between the input and output registers.
// A pending result stalls the input only when the next byte also ends a datagram.
// Reset (rst_ni low, asynchronous): window limits 1280..1407, counters zero,
//   frame state cleared, both pipeline registers empty. No clearing pass.
// ----------------------------------------------------------------------------
// space_packet_crc_apid_checker: space packet CRC and APID validator
// Streams datagram bytes in, emits one verdict with counters per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module space_packet_crc_apid_checker
  import sppc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Byte stream in
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  wire logic                s_axis_tlast,   // last_byte
  // Verdict stream out
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [10:0] packet_apid, [26:11] computed_crc, [42:27] trailer_crc,
  // [54:43] frame_length, [86:55] accepted_count, [118:87] mismatch_count,
  // [150:119] reject_count, [151] zero pad
  output logic      [151:0]        m_axis_tdata,
  output logic      [1:0]          m_axis_tuser,   // [1:0] verdict
  // APB configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  sppc_limits_t limits;
  sppc_result_t result;

  logic         in_valid_q, in_valid_d;
  sppc_item_t   in_item_q, in_item_d;
  logic         out_valid_q, out_valid_d;
  sppc_result_t out_res_q, out_res_d;
  logic         go;
  logic         in_take;

  sppc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  // Input register advances unless a verdict would hit a full, stalled output register
  assign go            = in_valid_q && (!in_item_q.last_byte || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || go;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (in_take) begin
      in_valid_d          = 1'b1;
      in_item_d.data_byte = s_axis_tdata;
      in_item_d.last_byte = s_axis_tlast;
    end else if (go) begin
      in_valid_d = 1'b0;
    end
  end

  sppc_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .item_i   (in_item_q),
    .limits_i (limits),
    .result_o (result)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (go && in_item_q.last_byte) begin
      out_valid_d = 1'b1;
      out_res_d   = result;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.verdict;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.reject_count,
                          out_res_q.mismatch_count,
                          out_res_q.accepted_count,
                          out_res_q.frame_length,
                          out_res_q.trailer_crc,
                          out_res_q.computed_crc,
                          out_res_q.packet_apid};

`ifndef SYNTHESIS
  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !(go && in_item_q.last_byte))
    else $error("result register overwritten while stalled");

  // A new verdict always shows up on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && in_item_q.last_byte |=> m_axis_tvalid)
    else $error("verdict lost");

  // A byte that ends no datagram never stalls the input register
  a_no_stall_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_item_q.last_byte |-> go)
    else $error("mid-frame byte stalled");
`endif

endmodule

`default_nettype wire
